@@ rtl/stwf_pkg.sv @@
// ----------------------------------------------------------------------------
// stwf_pkg
// Shared types and constants of the symbol-time Wiener filter.
// ----------------------------------------------------------------------------
package stwf_pkg;

	localparam int MAX_TAPS     = 4;
	localparam int MAX_CARRIERS = 8192;

	localparam int SAMPLE_W  = 16;
	localparam int COEF_W    = 16;
	localparam int SLOT_W    = $clog2(MAX_TAPS);
	localparam int TAPS_W    = 3;
	localparam int LIDX_W    = $clog2(2 * MAX_TAPS);
	localparam int CARRIER_W = $clog2(MAX_CARRIERS);
	localparam int COUNT_W   = 14;
	localparam int ENTRY_W   = 2 * SAMPLE_W;
	localparam int WORD_W    = MAX_TAPS * ENTRY_W;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam int SAT_LIMIT = 32767;

	localparam logic [CFG_IDX_W-1:0] REG_CARRIER_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TAPS_IN_USE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_OLDEST   = 3'd2;

	localparam logic [COUNT_W-1:0] CARRIER_COUNT_RESET = 14'd6913;
	localparam logic [TAPS_W-1:0]  TAPS_RESET          = 3'd4;
	localparam logic [COEF_W-1:0]  COEF_RESET          = 16'd8192;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_re;
		logic signed [SAMPLE_W-1:0] sample_im;
	} channel_sample_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] estimate_re;
		logic signed [SAMPLE_W-1:0] estimate_im;
		logic                       was_filtered;
		logic                       symbol_end;
	} estimate_t;

endpackage

@@ rtl/stwf_ram.sv @@
// ----------------------------------------------------------------------------
// stwf_ram
// Simple dual-port synchronous RAM, one write and one read port, registered
// read data.
// ----------------------------------------------------------------------------
module stwf_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/symbol_time_wiener_filter.sv @@
// ----------------------------------------------------------------------------
// symbol_time_wiener_filter
// Time-direction FIR over per-carrier symbol histories of channel estimates.
// ----------------------------------------------------------------------------
// One complex estimate per carrier enters per word; one filtered (or, until
// the history ring has filled, passed-through) estimate leaves per word. All
// history taps of a carrier sit in one wide RAM word that is read, updated
// with the new sample and written back. Steps: RAM read, multiply with
// write-back, sum and saturate. No new word is taken until the sum step ends,
// which a full output register holds; the result waits there while the next
// word is taken. Configuration is to be written only while idle (unenforced);
// writing carrier_count or taps_in_use restarts the ring, history is kept.
// ----------------------------------------------------------------------------
module symbol_time_wiener_filter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_valid,
	output logic                                 sample_ready,
	input  stwf_pkg::channel_sample_t            sample,
	output logic                                 estimate_valid,
	input  logic                                 estimate_ready,
	output stwf_pkg::estimate_t                  estimate,
	input  logic                                 cfg_we,
	input  logic [stwf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [stwf_pkg::CFG_DATA_W-1:0]      cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM
	} state_t;

	typedef logic signed [2*stwf_pkg::SAMPLE_W:0] prod_t;
	typedef logic signed [stwf_pkg::SAMPLE_W+1:0] part_t;
	typedef logic signed [stwf_pkg::SAMPLE_W+3:0] acc_t;

	state_t state_q;

	logic [stwf_pkg::COUNT_W-1:0]   carrier_count_q;
	logic [stwf_pkg::TAPS_W-1:0]    taps_q;
	logic [stwf_pkg::COEF_W-1:0]    coef_q [stwf_pkg::MAX_TAPS];
	logic [stwf_pkg::SLOT_W-1:0]    write_slot_q;
	logic                           ring_filled_q;
	logic [stwf_pkg::CARRIER_W-1:0] carrier_index_q;

	logic [stwf_pkg::COUNT_W-1:0]   count_eff;
	logic [stwf_pkg::TAPS_W-1:0]    taps_eff;
	logic [stwf_pkg::CARRIER_W-1:0] k;
	logic                           last;
	logic                           filt;
	logic                           accept;
	logic [stwf_pkg::CFG_IDX_W-1:0] coef_sel;
	logic [stwf_pkg::SLOT_W:0]      slot_inc;

	stwf_pkg::channel_sample_t      sample_s1;
	logic [stwf_pkg::SLOT_W-1:0]    slot_s1;
	logic [stwf_pkg::TAPS_W-1:0]    taps_s1;
	logic [stwf_pkg::CARRIER_W-1:0] addr_s1;
	logic                           filt_s1;
	logic                           last_s1;

	stwf_pkg::channel_sample_t      sample_s2;
	logic                           filt_s2;
	logic                           last_s2;
	prod_t                          prod_re_s2 [stwf_pkg::MAX_TAPS];
	prod_t                          prod_im_s2 [stwf_pkg::MAX_TAPS];

	stwf_pkg::estimate_t            out_q;
	logic                           out_valid_q;

	logic [stwf_pkg::WORD_W-1:0]    rd_data;
	logic [stwf_pkg::MAX_TAPS-1:0][stwf_pkg::ENTRY_W-1:0] lanes;
	logic [stwf_pkg::MAX_TAPS-1:0][stwf_pkg::ENTRY_W-1:0] merged;
	prod_t                          prod_re [stwf_pkg::MAX_TAPS];
	prod_t                          prod_im [stwf_pkg::MAX_TAPS];
	acc_t                           sum_re;
	acc_t                           sum_im;
	logic signed [stwf_pkg::SAMPLE_W-1:0] res_re;
	logic signed [stwf_pkg::SAMPLE_W-1:0] res_im;
	logic                           out_free;

	function automatic part_t trunc15(input prod_t p);
		prod_t sh;
		sh = p >>> 15;
		if (p[2*stwf_pkg::SAMPLE_W] && (|p[14:0])) begin
			sh = sh + prod_t'(1);
		end
		return part_t'(sh);
	endfunction

	function automatic logic signed [stwf_pkg::SAMPLE_W-1:0] sat16(input acc_t v);
		if (v > acc_t'(stwf_pkg::SAT_LIMIT)) begin
			return stwf_pkg::SAMPLE_W'(stwf_pkg::SAT_LIMIT);
		end else if (v < -acc_t'(stwf_pkg::SAT_LIMIT)) begin
			return -stwf_pkg::SAMPLE_W'(stwf_pkg::SAT_LIMIT);
		end
		return v[stwf_pkg::SAMPLE_W-1:0];
	endfunction

	// effective geometry and carrier position
	always_comb begin
		if (carrier_count_q == '0) begin
			count_eff = stwf_pkg::COUNT_W'(1);
		end else if (carrier_count_q > stwf_pkg::COUNT_W'(stwf_pkg::MAX_CARRIERS)) begin
			count_eff = stwf_pkg::COUNT_W'(stwf_pkg::MAX_CARRIERS);
		end else begin
			count_eff = carrier_count_q;
		end
		if (taps_q == '0) begin
			taps_eff = stwf_pkg::TAPS_W'(1);
		end else if (taps_q > stwf_pkg::TAPS_W'(stwf_pkg::MAX_TAPS)) begin
			taps_eff = stwf_pkg::TAPS_W'(stwf_pkg::MAX_TAPS);
		end else begin
			taps_eff = taps_q;
		end
		if ({1'b0, carrier_index_q} >= stwf_pkg::COUNT_W'(count_eff)) begin
			k = stwf_pkg::CARRIER_W'(count_eff - stwf_pkg::COUNT_W'(1));
		end else begin
			k = carrier_index_q;
		end
		last     = (stwf_pkg::COUNT_W'(k) == count_eff - stwf_pkg::COUNT_W'(1));
		filt     = ring_filled_q ||
			(stwf_pkg::TAPS_W'(write_slot_q) == taps_eff - stwf_pkg::TAPS_W'(1));
		slot_inc = {1'b0, write_slot_q} + (stwf_pkg::SLOT_W+1)'(1);
		coef_sel = cfg_index - stwf_pkg::REG_COEF_OLDEST;
	end

	assign sample_ready = (state_q == ST_IDLE);
	assign accept       = sample_valid && sample_ready;

	// configuration and ring position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carrier_count_q <= stwf_pkg::CARRIER_COUNT_RESET;
			taps_q          <= stwf_pkg::TAPS_RESET;
			for (int t = 0; t < stwf_pkg::MAX_TAPS; t++) begin
				coef_q[t] <= stwf_pkg::COEF_RESET;
			end
			write_slot_q    <= '0;
			ring_filled_q   <= 1'b0;
			carrier_index_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == stwf_pkg::REG_CARRIER_COUNT) begin
				carrier_count_q <= cfg_data[stwf_pkg::COUNT_W-1:0];
				write_slot_q    <= '0;
				ring_filled_q   <= 1'b0;
				carrier_index_q <= '0;
			end else if (cfg_index == stwf_pkg::REG_TAPS_IN_USE) begin
				taps_q          <= cfg_data[stwf_pkg::TAPS_W-1:0];
				write_slot_q    <= '0;
				ring_filled_q   <= 1'b0;
				carrier_index_q <= '0;
			end else if (cfg_index >= stwf_pkg::REG_COEF_OLDEST &&
				coef_sel < stwf_pkg::CFG_IDX_W'(stwf_pkg::MAX_TAPS)) begin
				coef_q[coef_sel[stwf_pkg::SLOT_W-1:0]] <= cfg_data[stwf_pkg::COEF_W-1:0];
			end
		end else if (accept) begin
			if (last) begin
				carrier_index_q <= '0;
				if (stwf_pkg::TAPS_W'(slot_inc) == taps_eff) begin
					write_slot_q  <= '0;
					ring_filled_q <= 1'b1;
				end else begin
					write_slot_q <= slot_inc[stwf_pkg::SLOT_W-1:0];
				end
			end else begin
				carrier_index_q <= k + stwf_pkg::CARRIER_W'(1);
			end
		end
	end

	stwf_ram #(
		.WIDTH (stwf_pkg::WORD_W),
		.DEPTH (stwf_pkg::MAX_CARRIERS)
	) u_history (
		.clk     (clk),
		.wr_en   (state_q == ST_MUL),
		.wr_addr (addr_s1),
		.wr_data (merged),
		.rd_en   (accept),
		.rd_addr (k),
		.rd_data (rd_data)
	);

	// merge new sample into the carrier word and weigh each tap
	always_comb begin
		logic [stwf_pkg::LIDX_W-1:0] lidx;
		logic [stwf_pkg::ENTRY_W-1:0] ent;
		lanes = rd_data;
		for (int l = 0; l < stwf_pkg::MAX_TAPS; l++) begin
			if (stwf_pkg::SLOT_W'(l) == slot_s1) begin
				merged[l] = {sample_s1.sample_im, sample_s1.sample_re};
			end else begin
				merged[l] = lanes[l];
			end
		end
		for (int t = 0; t < stwf_pkg::MAX_TAPS; t++) begin
			lidx = stwf_pkg::LIDX_W'(slot_s1) + stwf_pkg::LIDX_W'(1) + stwf_pkg::LIDX_W'(t);
			if (lidx >= stwf_pkg::LIDX_W'(taps_s1)) begin
				lidx = lidx - stwf_pkg::LIDX_W'(taps_s1);
			end
			ent = merged[lidx[stwf_pkg::SLOT_W-1:0]];
			if (stwf_pkg::TAPS_W'(t) < taps_s1) begin
				prod_re[t] = $signed({1'b0, coef_q[t]}) *
					$signed(ent[stwf_pkg::SAMPLE_W-1:0]);
				prod_im[t] = $signed({1'b0, coef_q[t]}) *
					$signed(ent[stwf_pkg::ENTRY_W-1:stwf_pkg::SAMPLE_W]);
			end else begin
				prod_re[t] = '0;
				prod_im[t] = '0;
			end
		end
	end

	// truncate, accumulate, saturate
	always_comb begin
		sum_re = '0;
		sum_im = '0;
		for (int t = 0; t < stwf_pkg::MAX_TAPS; t++) begin
			sum_re = sum_re + acc_t'(trunc15(prod_re_s2[t]));
			sum_im = sum_im + acc_t'(trunc15(prod_im_s2[t]));
		end
		if (filt_s2) begin
			res_re = sat16(sum_re);
			res_im = sat16(sum_im);
		end else begin
			res_re = sat16(acc_t'(sample_s2.sample_re));
			res_im = sat16(acc_t'(sample_s2.sample_im));
		end
		out_free = !out_valid_q || estimate_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_SUM && out_free) begin
				out_valid_q <= 1'b1;
			end else if (estimate_valid && estimate_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath stage registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
			slot_s1   <= write_slot_q;
			taps_s1   <= taps_eff;
			addr_s1   <= k;
			filt_s1   <= filt;
			last_s1   <= last;
		end
		if (state_q == ST_MUL) begin
			sample_s2 <= sample_s1;
			filt_s2   <= filt_s1;
			last_s2   <= last_s1;
			for (int t = 0; t < stwf_pkg::MAX_TAPS; t++) begin
				prod_re_s2[t] <= prod_re[t];
				prod_im_s2[t] <= prod_im[t];
			end
		end
		if (state_q == ST_SUM && out_free) begin
			out_q.estimate_re  <= res_re;
			out_q.estimate_im  <= res_im;
			out_q.was_filtered <= filt_s2;
			out_q.symbol_end   <= last_s2;
		end
	end

	assign estimate_valid = out_valid_q;
	assign estimate       = out_q;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the symbol-time Wiener filter.
// ----------------------------------------------------------------------------
// Streams complex channel estimates through the filter under a series of
// ring geometries and tap weights. A behavioral copy of the per-carrier
// history ring, written in plain integer arithmetic, predicts every output
// word, and each accepted output is compared field by field in order.
// In the random phases both handshakes stall in random bursts, but not in the closing stretch.
// ----------------------------------------------------------------------------
module tb;

	localparam logic [stwf_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [stwf_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam int RANDOM_WORDS = 450;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            sample_valid = 1'b0;
	logic                            sample_ready;
	stwf_pkg::channel_sample_t       sample = '0;
	logic                            estimate_valid;
	logic                            estimate_ready = 1'b0;
	stwf_pkg::estimate_t             estimate;
	logic                            cfg_we = 1'b0;
	logic [stwf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [stwf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	stwf_pkg::channel_sample_t sample_backlog[$];
	stwf_pkg::estimate_t       estimate_expected[$];

	int send_odds = 0;
	int take_odds = 0;
	int gap_left = 0;
	int stall_left = 0;
	int error_count = 0;
	int words_in = 0;
	int words_out = 0;
	int filtered_seen = 0;
	int symbols_seen = 0;
	int phase_count = 0;

	// predictor state
	stwf_pkg::channel_sample_t    ring_hist[stwf_pkg::MAX_TAPS][stwf_pkg::MAX_CARRIERS];
	int                           ring_slot;
	bit                           ring_full;
	int                           carrier_pos;
	logic [stwf_pkg::COUNT_W-1:0] cur_count;
	logic [stwf_pkg::TAPS_W-1:0]  cur_taps;
	logic [stwf_pkg::COEF_W-1:0]  cur_coef[stwf_pkg::MAX_TAPS];

	symbol_time_wiener_filter dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_ready   (sample_ready),
		.sample         (sample),
		.estimate_valid (estimate_valid),
		.estimate_ready (estimate_ready),
		.estimate       (estimate),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint weigh(logic [stwf_pkg::COEF_W-1:0] c,
			logic signed [stwf_pkg::SAMPLE_W-1:0] x);
		longint cv;
		longint xv;
		cv = c;
		xv = x;
		return (cv * xv) / 32768;
	endfunction

	function automatic logic signed [stwf_pkg::SAMPLE_W-1:0] clip(longint v);
		if (v > stwf_pkg::SAT_LIMIT)
			return stwf_pkg::SAMPLE_W'(stwf_pkg::SAT_LIMIT);
		if (v < -stwf_pkg::SAT_LIMIT)
			return -stwf_pkg::SAMPLE_W'(stwf_pkg::SAT_LIMIT);
		return v[stwf_pkg::SAMPLE_W-1:0];
	endfunction

	function automatic int taps_eff();
		if (cur_taps == 0)
			return 1;
		if (cur_taps > stwf_pkg::MAX_TAPS)
			return stwf_pkg::MAX_TAPS;
		return cur_taps;
	endfunction

	function automatic int count_eff();
		if (cur_count == 0)
			return 1;
		if (cur_count > stwf_pkg::MAX_CARRIERS)
			return stwf_pkg::MAX_CARRIERS;
		return cur_count;
	endfunction

	task automatic filter_estimate(input stwf_pkg::channel_sample_t s,
			output stwf_pkg::estimate_t e);
		int taps;
		int count;
		int slot;
		int k;
		int hs;
		longint sr;
		longint si;
		bit filt;
		bit last;
		taps = taps_eff();
		count = count_eff();
		slot = ring_slot % taps;
		k = carrier_pos;
		if (k >= count)
			k = count - 1;
		last = (k == count - 1);
		ring_hist[slot][k] = s;
		filt = ring_full || (slot == taps - 1);
		sr = 0;
		si = 0;
		if (filt) begin
			for (int t = 0; t < taps; t++) begin
				hs = (slot + 1 + t) % taps;
				sr += weigh(cur_coef[t], ring_hist[hs][k].sample_re);
				si += weigh(cur_coef[t], ring_hist[hs][k].sample_im);
			end
		end else begin
			sr = s.sample_re;
			si = s.sample_im;
		end
		e.estimate_re = clip(sr);
		e.estimate_im = clip(si);
		e.was_filtered = filt;
		e.symbol_end = last;
		if (last) begin
			carrier_pos = 0;
			slot = (slot + 1) % taps;
			if (slot == 0)
				ring_full = 1'b1;
		end else begin
			carrier_pos = k + 1;
		end
		ring_slot = slot;
	endtask

	task automatic write_reg(input logic [stwf_pkg::CFG_IDX_W-1:0] idx,
			input logic [stwf_pkg::CFG_DATA_W-1:0] d);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		if (idx == stwf_pkg::REG_CARRIER_COUNT || idx == stwf_pkg::REG_TAPS_IN_USE) begin
			if (idx == stwf_pkg::REG_CARRIER_COUNT)
				cur_count = d[stwf_pkg::COUNT_W-1:0];
			else
				cur_taps = d[stwf_pkg::TAPS_W-1:0];
			ring_slot = 0;
			ring_full = 1'b0;
			carrier_pos = 0;
		end else if (idx >= stwf_pkg::REG_COEF_OLDEST &&
				idx < stwf_pkg::REG_COEF_OLDEST + stwf_pkg::MAX_TAPS) begin
			cur_coef[idx - stwf_pkg::REG_COEF_OLDEST] = d;
		end
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_geometry(input int count, input int taps);
		write_reg(stwf_pkg::REG_CARRIER_COUNT, stwf_pkg::CFG_DATA_W'(count));
		write_reg(stwf_pkg::REG_TAPS_IN_USE, stwf_pkg::CFG_DATA_W'(taps));
	endtask

	task automatic set_coefs(input int c0, input int c1, input int c2, input int c3);
		write_reg(stwf_pkg::REG_COEF_OLDEST, stwf_pkg::CFG_DATA_W'(c0));
		write_reg(stwf_pkg::REG_COEF_OLDEST + 3'd1, stwf_pkg::CFG_DATA_W'(c1));
		write_reg(stwf_pkg::REG_COEF_OLDEST + 3'd2, stwf_pkg::CFG_DATA_W'(c2));
		write_reg(stwf_pkg::REG_COEF_OLDEST + 3'd3, stwf_pkg::CFG_DATA_W'(c3));
	endtask

	task automatic push_word(input int re, input int im);
		stwf_pkg::channel_sample_t s;
		s.sample_re = stwf_pkg::SAMPLE_W'(re);
		s.sample_im = stwf_pkg::SAMPLE_W'(im);
		sample_backlog.push_back(s);
	endtask

	task automatic drain();
		@(negedge clk);
		while (sample_backlog.size() != 0 || sample_valid || estimate_expected.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
		phase_count++;
	endtask

	function automatic int pick_value();
		case ($urandom_range(0, 7))
			0: return -32768;
			1: return 32767;
			2: return 0;
			3: return -1;
			default: return $signed(16'($urandom()));
		endcase
	endfunction

	function automatic int pick_coef();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 32768;
			2: return 65535;
			3: return $urandom_range(0, 65535);
			default: return $urandom_range(0, 32768);
		endcase
	endfunction

	function automatic int pick_idle();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 3;
			default: return $urandom_range(5, 16);
		endcase
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			gap_left <= 0;
		end else if (!sample_valid || sample_ready) begin
			if (gap_left != 0) begin
				sample_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (sample_backlog.size() != 0 && send_odds != 0
					&& $urandom_range(1, send_odds) == 1) begin
				sample_valid <= 1'b0;
				gap_left <= $urandom_range(0, 14);
			end else if (sample_backlog.size() != 0) begin
				sample <= sample_backlog.pop_front();
				sample_valid <= 1'b1;
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			estimate_ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			estimate_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (take_odds != 0 && $urandom_range(1, take_odds) == 1) begin
			estimate_ready <= 1'b0;
			stall_left <= $urandom_range(0, 14);
		end else begin
			estimate_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		stwf_pkg::estimate_t got;
		stwf_pkg::estimate_t want;
		if (arst_n) begin
			if (estimate_valid && estimate_ready) begin
				got = estimate;
				words_out++;
				if (got.was_filtered === 1'b1)
					filtered_seen++;
				if (got.symbol_end === 1'b1)
					symbols_seen++;
				if (estimate_expected.size() == 0) begin
					$error("unexpected output word re=%0d im=%0d", got.estimate_re,
						got.estimate_im);
					error_count++;
				end else begin
					want = estimate_expected.pop_front();
					if (got.estimate_re !== want.estimate_re) begin
						$error("estimate_re expected %0d got %0d", want.estimate_re,
							got.estimate_re);
						error_count++;
					end
					if (got.estimate_im !== want.estimate_im) begin
						$error("estimate_im expected %0d got %0d", want.estimate_im,
							got.estimate_im);
						error_count++;
					end
					if (got.was_filtered !== want.was_filtered) begin
						$error("was_filtered expected %0b got %0b", want.was_filtered,
							got.was_filtered);
						error_count++;
					end
					if (got.symbol_end !== want.symbol_end) begin
						$error("symbol_end expected %0b got %0b", want.symbol_end,
							got.symbol_end);
						error_count++;
					end
				end
			end
			if (sample_valid && sample_ready) begin
				filter_estimate(sample, want);
				estimate_expected.push_back(want);
				words_in++;
			end
		end
	end

	initial begin
		#5ms;
		$display("symbol_time_wiener_filter verification failed");
		$finish;
	end

	initial begin
		int random_words;
		int count;
		int taps;
		int n;
		ring_slot = 0;
		ring_full = 1'b0;
		carrier_pos = 0;
		cur_count = stwf_pkg::CARRIER_COUNT_RESET;
		cur_taps = stwf_pkg::TAPS_RESET;
		for (int t = 0; t < stwf_pkg::MAX_TAPS; t++)
			cur_coef[t] = stwf_pkg::COEF_RESET;
		random_words = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset geometry: long symbol, ring never fills, pass-through
		push_word(-32768, 32767);
		push_word(32767, -32768);
		push_word(0, -1);
		push_word(-1, 0);
		drain();

		// two carriers, two taps, unity weights: sums saturate both ways
		set_geometry(2, 2);
		set_coefs(32768, 32768, 8192, 8192);
		write_reg(REG_SPARE_LO, 16'hFFFF);
		write_reg(REG_SPARE_HI, 16'h0001);
		end_writes();
		push_word(32767, -32768);
		push_word(-32768, 32767);
		push_word(32767, -32768);
		push_word(-32768, 32767);
		push_word(100, -100);
		push_word(-7, 7);
		drain();

		// zero geometry acts as one carrier, one tap; oversized weight
		set_geometry(0, 0);
		set_coefs(65535, 0, 0, 0);
		end_writes();
		push_word(32767, -32768);
		push_word(-3, 3);
		push_word(1, -1);
		push_word(-32768, 16384);
		drain();

		// oversized geometry clamps to the maximum: pass-through only
		set_geometry(16383, 7);
		set_coefs(0, 32768, 1, 32767);
		end_writes();
		for (int i = 0; i < 6; i++)
			push_word(pick_value(), pick_value());
		drain();

		while (random_words < RANDOM_WORDS) begin
			if (random_words >= RANDOM_WORDS - 90) begin
				send_odds = 0;
				take_odds = 0;
			end else begin
				send_odds = pick_idle();
				take_odds = pick_idle();
			end
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 9))
					0: taps = 0;
					1: taps = $urandom_range(5, 7);
					default: taps = $urandom_range(1, 4);
				endcase
				case ($urandom_range(0, 9))
					0: count = 0;
					1: count = $urandom_range(13, 40);
					default: count = $urandom_range(1, 12);
				endcase
				set_geometry(count, taps);
			end
			set_coefs(pick_coef(), pick_coef(), pick_coef(), pick_coef());
			if ($urandom_range(0, 7) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
					stwf_pkg::CFG_DATA_W'($urandom()));
			end_writes();
			n = count_eff() * taps_eff() * $urandom_range(1, 3) + $urandom_range(0, count_eff());
			if (n > 120)
				n = 120;
			if (n > RANDOM_WORDS - random_words)
				n = RANDOM_WORDS - random_words;
			for (int i = 0; i < n; i++)
				push_word(pick_value(), pick_value());
			random_words += n;
			drain();
		end

		repeat (10) @(posedge clk);
		$display("%0d words in, %0d out over %0d phases", words_in, words_out, phase_count);
		$display("%0d filtered outputs, %0d symbol ends", filtered_seen, symbols_seen);
		if (error_count == 0 && estimate_expected.size() == 0) begin
			$display("symbol_time_wiener_filter verification clean");
		end else begin
			$display("symbol_time_wiener_filter verification failed");
		end
		$finish;
	end

endmodule

@@ symbol_time_wiener_filter.f @@
rtl/stwf_pkg.sv
rtl/stwf_ram.sv
rtl/symbol_time_wiener_filter.sv
sim/tb.sv
